@@ sv/utf8_display_width_meter_unit_assert.svh @@
// assertion macros used by the port-level checker of the utf8 width meter
`ifndef UTF8_DISPLAY_WIDTH_METER_UNIT_ASSERT_SVH
`define UTF8_DISPLAY_WIDTH_METER_UNIT_ASSERT_SVH

// property checked on every rising clock edge outside reset
`define UDWM_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// property checked on every rising clock edge, reset included
`define UDWM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

@@ sv/udwm_pkg.sv @@
// types, constants and the width table of the utf8 display width meter
package udwm_pkg;

  localparam int BYTE_W     = 8;
  localparam int CP_W       = 21;
  localparam int CW_W       = 2;
  localparam int TOTAL_W    = 16;
  localparam int PEND_DEPTH = 3;
  localparam int SLOTS      = PEND_DEPTH + 1;
  localparam int SLOT_IDX_W = $clog2(SLOTS);
  localparam int SLOT_CNT_W = $clog2(SLOTS + 1);
  localparam int PEND_IDX_W = $clog2(PEND_DEPTH);

  // result tdata layout, lowest bit first
  localparam int CP_LSB     = 0;
  localparam int CW_LSB     = CP_LSB + CP_W;
  localparam int RAW_BIT    = CW_LSB + CW_W;
  localparam int TOT_LSB    = RAW_BIT + 1;
  localparam int OUT_BITS   = TOT_LSB + TOTAL_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // lead byte classes
  localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD2_CODE = 8'hC0;
  localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD3_CODE = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
  localparam logic [BYTE_W-1:0] LEAD4_CODE = 8'hF0;
  localparam logic [BYTE_W-1:0] CONT_MASK  = 8'hC0;
  localparam logic [BYTE_W-1:0] CONT_CODE  = 8'h80;

  localparam logic [CP_W-1:0] MIN_LEN2 = 21'h00080;
  localparam logic [CP_W-1:0] MIN_LEN3 = 21'h00800;
  localparam logic [CP_W-1:0] MIN_LEN4 = 21'h10000;
  localparam logic [CP_W-1:0] CP_MAX   = 21'h10FFFF;
  localparam logic [CP_W-1:0] SURR_LO  = 21'h0D800;
  localparam logic [CP_W-1:0] SURR_HI  = 21'h0DFFF;

  typedef logic [2:0] seq_len_t;
  localparam seq_len_t LEN_NONE = 3'd0;
  localparam seq_len_t LEN2     = 3'd2;
  localparam seq_len_t LEN3     = 3'd3;
  localparam seq_len_t LEN4     = 3'd4;

  localparam logic [CW_W-1:0] CW_ZERO   = 2'd0;
  localparam logic [CW_W-1:0] CW_NARROW = 2'd1;
  localparam logic [CW_W-1:0] CW_WIDE   = 2'd2;

  typedef struct packed {
    logic [CP_W-1:0] cp;
    logic            raw;
    logic            run_end;
    logic            str_end;
  } slot_t;

  function automatic logic [CW_W-1:0] width_of(input logic [CP_W-1:0] cp);
    logic ctrl;
    logic comb;
    logic wide;
    ctrl = (cp < 21'h00020) || (cp >= 21'h0007F && cp < 21'h000A0);
    comb = (cp >= 21'h00300 && cp <= 21'h0036F) || (cp >= 21'h01AB0 && cp <= 21'h01AFF) ||
           (cp >= 21'h01DC0 && cp <= 21'h01DFF) || (cp >= 21'h020D0 && cp <= 21'h020FF) ||
           (cp >= 21'h0FE20 && cp <= 21'h0FE2F);
    wide = (cp >= 21'h01100 && cp <= 21'h0115F) || cp == 21'h02329 || cp == 21'h0232A ||
           (cp >= 21'h02E80 && cp <= 21'h0303E) || (cp >= 21'h03040 && cp <= 21'h0A4CF) ||
           (cp >= 21'h0AC00 && cp <= 21'h0D7A3) || (cp >= 21'h0F900 && cp <= 21'h0FAFF) ||
           (cp >= 21'h0FE10 && cp <= 21'h0FE19) || (cp >= 21'h0FE30 && cp <= 21'h0FE6F) ||
           (cp >= 21'h0FF00 && cp <= 21'h0FF60) || (cp >= 21'h0FFE0 && cp <= 21'h0FFE6);
    if (ctrl || comb) begin
      return CW_ZERO;
    end else if (wide) begin
      return CW_WIDE;
    end
    return CW_NARROW;
  endfunction

endpackage

@@ sv/utf8_display_width_meter_unit.sv @@
// utf8 decoder with per-code-point display width and running string width
// Takes one byte per transfer on the s side and gives decoded code points with their display
// width (0, 1 or 2 columns) and a running width that saturates at 65535 and restarts after
// the byte marked tlast. Bytes that only extend a multi-byte sequence give no result; a byte
// that ends a sequence, or breaks one, gives one to four results (failed sequences come out
// byte by byte, flagged raw). A byte is decoded in the cycle it is taken and its results go
// into a four-entry result buffer, which drains through the output register at one result per
// cycle while the receiver takes them; a result passes through that buffer and the output
// register to the m side. Input is taken every cycle while each byte gives at most one result
// and the receiver keeps up; a byte with more results holds off the next byte while the buffer
// drains. m_tlast marks the final result of a string and m_tuser the last result of one byte.
module utf8_display_width_meter_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [udwm_pkg::BYTE_W-1:0]    s_tdata,  // [7:0] in_byte
  input  logic                           s_tlast,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [20:0] code_point, [22:21] char_width, [23] was_raw, [39:24] width_so_far
  output logic [udwm_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                           m_tlast,
  output logic                           m_tuser   // [0] run_end
);
  import udwm_pkg::*;

  logic [BYTE_W-1:0]     pend [PEND_DEPTH];
  logic [1:0]            pcount;
  logic [1:0]            pcount_next;
  seq_len_t              elen;
  seq_len_t              elen_next;

  slot_t                 slots [SLOTS];
  slot_t                 new_slot [SLOTS];
  logic [SLOT_IDX_W-1:0] head;
  logic [SLOT_CNT_W-1:0] left;
  logic [TOTAL_W-1:0]    total;

  logic                  accept;
  logic                  pop;
  logic                  ascii;
  logic                  is_cont;
  seq_len_t              lead_len;
  logic                  scan_hold;
  logic                  complete;
  logic [CP_W-1:0]       seq_cp;
  logic [CP_W-1:0]       seq_min;
  logic                  seq_bad;
  logic [1:0]            flush_k;
  logic                  tail_v;
  logic [CP_W-1:0]       tail_cp;
  logic                  tail_raw;
  logic [SLOT_CNT_W-1:0] n_res;
  logic                  wr_en;
  logic [PEND_IDX_W-1:0] wr_idx;
  logic [BYTE_W-1:0]     held [SLOTS];

  slot_t                 hs;
  logic [CW_W-1:0]       hw;
  logic [TOTAL_W:0]      sum;
  logic [TOTAL_W-1:0]    sum_sat;

  assign accept   = s_tvalid && s_tready;
  assign pop      = (left != '0) && (!m_tvalid || m_tready);
  assign s_tready = (left == '0) || (left == SLOT_CNT_W'(1) && pop);

  // byte classification
  assign ascii   = !s_tdata[BYTE_W-1];
  assign is_cont = (s_tdata & CONT_MASK) == CONT_CODE;

  always_comb begin
    priority if ((s_tdata & LEAD2_MASK) == LEAD2_CODE) begin
      lead_len = LEN2;
    end else if ((s_tdata & LEAD3_MASK) == LEAD3_CODE) begin
      lead_len = LEN3;
    end else if ((s_tdata & LEAD4_MASK) == LEAD4_CODE) begin
      lead_len = LEN4;
    end else begin
      lead_len = LEN_NONE;
    end
  end

  assign scan_hold = !ascii && (lead_len != LEN_NONE) && !s_tlast;
  assign complete  = ({1'b0, pcount} + 3'd1) >= elen;

  // code point of a sequence that this byte completes
  always_comb begin
    unique case (elen)
      LEN2: begin
        seq_cp  = {10'b0, pend[0][4:0], s_tdata[5:0]};
        seq_min = MIN_LEN2;
      end
      LEN3: begin
        seq_cp  = {5'b0, pend[0][3:0], pend[1][5:0], s_tdata[5:0]};
        seq_min = MIN_LEN3;
      end
      default: begin
        seq_cp  = {pend[0][2:0], pend[1][5:0], pend[2][5:0], s_tdata[5:0]};
        seq_min = MIN_LEN4;
      end
    endcase
  end

  assign seq_bad = (seq_cp < seq_min) || (seq_cp > CP_MAX) ||
                   (seq_cp >= SURR_LO && seq_cp <= SURR_HI);

  // result list is the flushed held bytes followed by at most one tail result
  always_comb begin
    flush_k     = 2'd0;
    tail_v      = 1'b0;
    tail_cp     = {{(CP_W-BYTE_W){1'b0}}, s_tdata};
    tail_raw    = 1'b1;
    pcount_next = pcount;
    elen_next   = elen;
    wr_en       = 1'b0;
    wr_idx      = pcount[PEND_IDX_W-1:0];
    if (pcount == 2'd0 || !is_cont) begin
      flush_k  = pcount;
      tail_v   = !scan_hold;
      tail_raw = !ascii;
      if (scan_hold) begin
        wr_en       = 1'b1;
        wr_idx      = '0;
        pcount_next = 2'd1;
        elen_next   = lead_len;
      end else begin
        pcount_next = 2'd0;
        elen_next   = LEN_NONE;
      end
    end else if (complete) begin
      tail_v      = 1'b1;
      pcount_next = 2'd0;
      elen_next   = LEN_NONE;
      if (seq_bad) begin
        flush_k = pcount;
      end else begin
        tail_cp  = seq_cp;
        tail_raw = 1'b0;
      end
    end else begin
      wr_en       = 1'b1;
      pcount_next = pcount + 2'd1;
      // truncated by end of string: held bytes and this one go out raw
      if (s_tlast) begin
        flush_k = pcount;
        tail_v  = 1'b1;
      end
    end
    if (s_tlast) begin
      pcount_next = 2'd0;
      elen_next   = LEN_NONE;
    end
  end

  assign n_res = SLOT_CNT_W'(flush_k) + SLOT_CNT_W'(tail_v);

  always_comb begin
    for (int i = 0; i < PEND_DEPTH; i++) begin
      held[i] = pend[i];
    end
    held[SLOTS-1] = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (2'(i) < flush_k && i < PEND_DEPTH) begin
        new_slot[i].cp  = {{(CP_W-BYTE_W){1'b0}}, held[i]};
        new_slot[i].raw = 1'b1;
      end else begin
        new_slot[i].cp  = tail_cp;
        new_slot[i].raw = tail_raw;
      end
      new_slot[i].run_end = SLOT_CNT_W'(i + 1) == n_res;
      new_slot[i].str_end = (SLOT_CNT_W'(i + 1) == n_res) && s_tlast;
    end
  end

  // head of the result buffer, width and running total
  assign hs      = slots[head];
  assign hw      = width_of(hs.cp);
  assign sum     = {1'b0, total} + {{(TOTAL_W+1-CW_W){1'b0}}, hw};
  assign sum_sat = sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      pcount   <= 2'd0;
      elen     <= LEN_NONE;
      left     <= '0;
      head     <= '0;
      total    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        pcount <= pcount_next;
        elen   <= elen_next;
        left   <= n_res;
        head   <= '0;
      end else if (pop) begin
        left <= left - SLOT_CNT_W'(1);
        head <= head + SLOT_IDX_W'(1);
      end
      if (pop) begin
        m_tvalid <= 1'b1;
        total    <= hs.str_end ? '0 : sum_sat;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      pend[wr_idx] <= s_tdata;
    end
    if (accept) begin
      for (int i = 0; i < SLOTS; i++) begin
        slots[i] <= new_slot[i];
      end
    end
    if (pop) begin
      m_tdata <= OUT_DATA_W'({sum_sat, hs.raw, hw, hs.cp});
      m_tlast <= hs.str_end;
      m_tuser <= hs.run_end;
    end
  end

endmodule

@@ sv/udwm_checker.sv @@
// port-level checker for the utf8 width meter, bound to the top level
`include "utf8_display_width_meter_unit_assert.svh"

module udwm_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [udwm_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic                           m_tlast
);
  import udwm_pkg::*;

  logic [TOTAL_W-1:0] base;
  logic               at_start;
  logic [TOTAL_W:0]   exp_sum;
  logic [TOTAL_W-1:0] exp_width;
  logic [CW_W-1:0]    cw;
  logic [TOTAL_W-1:0] shown;

  assign cw        = m_tdata[CW_LSB +: CW_W];
  assign shown     = m_tdata[TOT_LSB +: TOTAL_W];
  assign exp_sum   = {1'b0, at_start ? {TOTAL_W{1'b0}} : base} +
                     {{(TOTAL_W+1-CW_W){1'b0}}, cw};
  assign exp_width = exp_sum[TOTAL_W] ? {TOTAL_W{1'b1}} : exp_sum[TOTAL_W-1:0];

  // running width seen on the port, restarted after each string
  always_ff @(posedge clk) begin
    if (rst) begin
      base     <= '0;
      at_start <= 1'b1;
    end else if (m_tvalid && m_tready) begin
      base     <= shown;
      at_start <= m_tlast;
    end
  end

  `UDWM_ASSERT(a_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result dropped or changed while stalled")
  `UDWM_ASSERT_ALWAYS(a_rst_idle, clk, rst |=> !m_tvalid, "result valid right after reset")
  `UDWM_ASSERT(a_width_sum, clk, rst, m_tvalid |-> shown == exp_width, "running width does not follow char widths")
  `UDWM_ASSERT(a_raw_byte, clk, rst, m_tvalid && m_tdata[RAW_BIT] |-> m_tdata[CW_LSB-1:BYTE_W] == '0, "raw result wider than one byte")

endmodule

bind utf8_display_width_meter_unit udwm_checker u_udwm_checker (.*);

@@ sim/utf8_width_checker.sv @@
// checker for the utf8 width meter: predicts results per byte transfer and compares them
module utf8_width_checker
  import udwm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [BYTE_W-1:0]     s_tdata,   // [7:0] in_byte
  input  logic                  s_tlast,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  // [20:0] code_point, [22:21] char_width, [23] was_raw, [39:24] width_so_far
  input  logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  m_tlast,
  input  logic                  m_tuser,   // [0] run_end
  output int                    outstanding,
  output int                    fail_count,
  output int                    result_count
);

  typedef struct packed {
    logic [CP_W-1:0]    cp;
    logic [CW_W-1:0]    cols;
    logic               raw;
    logic [TOTAL_W-1:0] total;
    logic               run_end;
    logic               str_end;
  } glyph_t;

  logic [BYTE_W-1:0]  held [PEND_DEPTH];
  logic [1:0]         held_cnt;
  seq_len_t           held_len;
  logic [TOTAL_W-1:0] col_total;
  glyph_t             step_glyphs[$];
  glyph_t             glyphs_due[$];
  int                 errs;
  int                 checked;

  function automatic logic [CW_W-1:0] display_cols(input logic [CP_W-1:0] cp);
    if (cp < 21'h20 || (cp >= 21'h7F && cp < 21'hA0)) return CW_ZERO;
    // combining marks
    if ((cp >= 21'h0300 && cp <= 21'h036F) || (cp >= 21'h1AB0 && cp <= 21'h1AFF) ||
        (cp >= 21'h1DC0 && cp <= 21'h1DFF) || (cp >= 21'h20D0 && cp <= 21'h20FF) ||
        (cp >= 21'hFE20 && cp <= 21'hFE2F))
      return CW_ZERO;
    // east asian wide
    if ((cp >= 21'h1100 && cp <= 21'h115F) || cp == 21'h2329 || cp == 21'h232A ||
        (cp >= 21'h2E80 && cp <= 21'h303E) || (cp >= 21'h3040 && cp <= 21'hA4CF) ||
        (cp >= 21'hAC00 && cp <= 21'hD7A3) || (cp >= 21'hF900 && cp <= 21'hFAFF) ||
        (cp >= 21'hFE10 && cp <= 21'hFE19) || (cp >= 21'hFE30 && cp <= 21'hFE6F) ||
        (cp >= 21'hFF00 && cp <= 21'hFF60) || (cp >= 21'hFFE0 && cp <= 21'hFFE6))
      return CW_WIDE;
    return CW_NARROW;
  endfunction

  task automatic put_glyph(input logic [CP_W-1:0] cp, input logic raw);
    logic [CW_W-1:0]  w;
    logic [TOTAL_W:0] sum;
    glyph_t           g;
    w = display_cols(cp);
    sum = {1'b0, col_total} + {{(TOTAL_W+1-CW_W){1'b0}}, w};
    if (sum > {1'b0, {TOTAL_W{1'b1}}}) sum = {1'b0, {TOTAL_W{1'b1}}};
    col_total = sum[TOTAL_W-1:0];
    g.cp = cp;
    g.cols = w;
    g.raw = raw;
    g.total = sum[TOTAL_W-1:0];
    g.run_end = 1'b0;
    g.str_end = 1'b0;
    step_glyphs.push_back(g);
  endtask

  task automatic flush_held();
    for (int i = 0; i < int'(held_cnt); i++) put_glyph({13'd0, held[i]}, 1'b1);
    held_cnt = 2'd0;
    held_len = LEN_NONE;
  endtask

  task automatic scan_lead(input logic [BYTE_W-1:0] b, input logic last);
    seq_len_t len;
    if (b < 8'h80) begin
      put_glyph({13'd0, b}, 1'b0);
      return;
    end
    if ((b & LEAD2_MASK) == LEAD2_CODE) len = LEN2;
    else if ((b & LEAD3_MASK) == LEAD3_CODE) len = LEN3;
    else if ((b & LEAD4_MASK) == LEAD4_CODE) len = LEN4;
    else len = LEN_NONE;
    // bad lead, or a lead that arrives as the final byte
    if (len == LEN_NONE || last) begin
      put_glyph({13'd0, b}, 1'b1);
      return;
    end
    held[0] = b;
    held_cnt = 2'd1;
    held_len = len;
  endtask

  task automatic predict_byte(input logic [BYTE_W-1:0] b, input logic last);
    logic [CP_W-1:0] acc;
    logic [CP_W-1:0] floor_cp;
    step_glyphs.delete();
    if (held_cnt == 0) begin
      scan_lead(b, last);
    end else if ((b & CONT_MASK) != CONT_CODE) begin
      flush_held();
      scan_lead(b, last);
    end else if (({1'b0, held_cnt} + 3'd1) >= held_len) begin
      case (held_len)
        LEN2: begin
          acc = {16'd0, held[0][4:0]};
          floor_cp = MIN_LEN2;
        end
        LEN3: begin
          acc = {17'd0, held[0][3:0]};
          floor_cp = MIN_LEN3;
        end
        default: begin
          acc = {18'd0, held[0][2:0]};
          floor_cp = MIN_LEN4;
        end
      endcase
      for (int i = 1; i < int'(held_cnt); i++) acc = (acc << 6) | {15'd0, held[i][5:0]};
      acc = (acc << 6) | {15'd0, b[5:0]};
      if (acc < floor_cp || acc > CP_MAX || (acc >= SURR_LO && acc <= SURR_HI)) begin
        flush_held();
        put_glyph({13'd0, b}, 1'b1);
      end else begin
        held_cnt = 2'd0;
        held_len = LEN_NONE;
        put_glyph(acc, 1'b0);
      end
    end else begin
      held[held_cnt] = b;
      held_cnt = held_cnt + 2'd1;
      if (last) flush_held();
    end
    if (step_glyphs.size() > 0) begin
      step_glyphs[step_glyphs.size()-1].run_end = 1'b1;
      step_glyphs[step_glyphs.size()-1].str_end = last;
    end
    foreach (step_glyphs[i]) glyphs_due.push_back(step_glyphs[i]);
    if (last) begin
      col_total = '0;
      held_cnt = 2'd0;
      held_len = LEN_NONE;
    end
  endtask

  always @(posedge clk) begin
    glyph_t got;
    glyph_t want;
    if (rst) begin
      foreach (held[i]) held[i] = '0;
      held_cnt = 2'd0;
      held_len = LEN_NONE;
      col_total = '0;
      glyphs_due.delete();
    end else begin
      if (s_tvalid && s_tready) predict_byte(s_tdata, s_tlast);
      if (m_tvalid && m_tready) begin
        got.cp = m_tdata[CP_LSB +: CP_W];
        got.cols = m_tdata[CW_LSB +: CW_W];
        got.raw = m_tdata[RAW_BIT];
        got.total = m_tdata[TOT_LSB +: TOTAL_W];
        got.run_end = m_tuser;
        got.str_end = m_tlast;
        checked++;
        if (glyphs_due.size() == 0) begin
          $display("%0t: unexpected result cp=%h cols=%0d raw=%0b total=%0d", $time,
                   got.cp, got.cols, got.raw, got.total);
          errs++;
        end else begin
          want = glyphs_due.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected cp=%h cols=%0d raw=%0b total=%0d run_end=%0b str_end=%0b",
                     $time, want.cp, want.cols, want.raw, want.total, want.run_end,
                     want.str_end);
            $display("%0t:          actual   cp=%h cols=%0d raw=%0b total=%0d run_end=%0b str_end=%0b",
                     $time, got.cp, got.cols, got.raw, got.total, got.run_end,
                     got.str_end);
            errs++;
          end
        end
      end
    end
    outstanding  <= glyphs_due.size();
    fail_count   <= errs;
    result_count <= checked;
  end

endmodule

@@ sim/tb_utf8_display_width_meter_unit.sv @@
// testbench top for the utf8 width meter: stimulus, receiver stalls, watchdog and verdict
module tb_utf8_display_width_meter_unit;

  localparam int RAND_BYTES = 170;
  localparam int LONG_HOLD  = 200;
  localparam int IDLE_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [udwm_pkg::BYTE_W-1:0] s_tdata = '0;   // [7:0] in_byte
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  // [20:0] code_point, [22:21] char_width, [23] was_raw, [39:24] width_so_far
  logic [udwm_pkg::OUT_DATA_W-1:0] m_tdata;
  logic m_tlast;
  logic m_tuser;                                // [0] run_end

  int outstanding;
  int fail_count;
  int result_count;
  int bytes_sent = 0;
  int strings_sent = 0;
  bit tx_free = 1'b0;
  bit rx_free = 1'b0;
  bit long_hold_req = 1'b0;
  logic [7:0] seq_bytes[$];

  // bit 8 marks the final byte of a string
  logic [8:0] opening_bytes [27] = '{
    9'h000, 9'h07F, 9'h141,                 // ascii control, del, letter
    9'h0C3, 9'h0A9,                         // two-byte letter
    9'h0C0, 9'h180,                         // overlong two-byte
    9'h0E4, 9'h0B8, 9'h0AD,                 // wide cjk
    9'h0ED, 9'h0A0, 9'h180,                 // surrogate
    9'h0F0, 9'h09F, 9'h098, 9'h080,         // four-byte emoji
    9'h0F4, 9'h090, 9'h080, 9'h180,         // above the code point ceiling, four raw results
    9'h1FF,                                 // bad lead
    9'h0E4, 9'h041,                         // bad continuation
    9'h0E4, 9'h1B8,                         // cut off by the end of the string
    9'h1C3                                  // lead as the final byte
  };

  int unsigned range_lo [18] = '{
    'h0, 'h80, 'hA0, 'h300, 'h800, 'hE000, 'h1100, 'h2329, 'h2E80,
    'h3040, 'hAC00, 'hF900, 'hFE10, 'hFF00, 'h1AB0, 'h1DC0, 'h20D0, 'h10000
  };
  int unsigned range_hi [18] = '{
    'h7F, 'h9F, 'h7FF, 'h36F, 'hD7FF, 'hFFFF, 'h115F, 'h232A, 'h303E,
    'hA4CF, 'hD7A3, 'hFAFF, 'hFE6F, 'hFFE6, 'h1AFF, 'h1DFF, 'h20FF, 'h10FFFF
  };

  utf8_display_width_meter_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .m_tuser(m_tuser)
  );

  utf8_width_checker width_chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .m_tuser(m_tuser),
    .outstanding(outstanding), .fail_count(fail_count), .result_count(result_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int tx_gap();
    int r;
    if (tx_free) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = tx_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_sent++;
    if (last) strings_sent++;
  endtask

  task automatic send_seq(input bit mark_last);
    foreach (seq_bytes[i]) send_byte(seq_bytes[i], mark_last && i == seq_bytes.size() - 1);
    seq_bytes.delete();
  endtask

  // drop valid after the last transfer and wait for every result
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic encode(input logic [20:0] cp, input int len);
    case (len)
      1: seq_bytes.push_back({1'b0, cp[6:0]});
      2: begin
        seq_bytes.push_back({3'b110, cp[10:6]});
        seq_bytes.push_back({2'b10, cp[5:0]});
      end
      3: begin
        seq_bytes.push_back({4'b1110, cp[15:12]});
        seq_bytes.push_back({2'b10, cp[11:6]});
        seq_bytes.push_back({2'b10, cp[5:0]});
      end
      default: begin
        seq_bytes.push_back({5'b11110, cp[20:18]});
        seq_bytes.push_back({2'b10, cp[17:12]});
        seq_bytes.push_back({2'b10, cp[11:6]});
        seq_bytes.push_back({2'b10, cp[5:0]});
      end
    endcase
  endtask

  function automatic int natural_len(input logic [20:0] cp);
    if (cp < 21'h80) return 1;
    if (cp < 21'h800) return 2;
    if (cp < 21'h10000) return 3;
    return 4;
  endfunction

  // random code point, range edges picked often to hit width boundaries
  task automatic put_valid_cp();
    int idx;
    int r;
    logic [20:0] cp;
    idx = $urandom_range(0, 17);
    r = $urandom_range(0, 9);
    if (r == 0) cp = 21'(range_lo[idx]);
    else if (r == 1) cp = 21'(range_hi[idx]);
    else cp = 21'($urandom_range(range_lo[idx], range_hi[idx]));
    encode(cp, natural_len(cp));
  endtask

  task automatic put_multi();
    int len;
    len = $urandom_range(2, 4);
    case (len)
      2: encode(21'($urandom_range('h80, 'h7FF)), 2);
      3: encode(21'($urandom_range('h800, 'hD7FF)), 3);
      default: encode(21'($urandom_range('h10000, 'h10FFFF)), 4);
    endcase
  endtask

  task automatic put_broken();
    int kind;
    int len;
    int idx;
    logic [7:0] b;
    logic [20:0] floor_cp;
    kind = $urandom_range(0, 5);
    case (kind)
      0: seq_bytes.push_back(8'($urandom_range(0, 255)));
      1: begin
        put_multi();
        repeat ($urandom_range(1, seq_bytes.size() - 1)) void'(seq_bytes.pop_back());
      end
      2: begin
        put_multi();
        idx = $urandom_range(1, seq_bytes.size() - 1);
        b = 8'($urandom_range(0, 255));
        if ((b & 8'hC0) == 8'h80) b = b ^ 8'h40;
        seq_bytes[idx] = b;
      end
      3: begin
        // overlong: value fits a shorter form
        len = $urandom_range(2, 4);
        floor_cp = (len == 2) ? 21'h80 : (len == 3) ? 21'h800 : 21'h10000;
        if ($urandom_range(0, 3) == 0) encode(floor_cp - 21'd1, len);
        else encode(21'($urandom_range(0, floor_cp - 21'd1)), len);
      end
      4: encode(21'($urandom_range('hD800, 'hDFFF)), 3);
      default: encode(21'($urandom_range('h110000, 'h1FFFFF)), 4);
    endcase
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int hold;
    int r;
    hold = 0;
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        m_tready <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold = LONG_HOLD - 1;
        m_tready <= 1'b0;
      end else if (rx_free) begin
        m_tready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          m_tready <= 1'b1;
        end else if (r < 97) begin
          hold = $urandom_range(0, 2);
          m_tready <= 1'b0;
        end else begin
          hold = $urandom_range(10, 50);
          m_tready <= 1'b0;
        end
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  initial begin
    int idle;
    idle = 0;
    wait (rst == 1'b0);
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle = 0;
      else idle++;
    end
    $display("tb_utf8_display_width_meter_unit failed");
    $finish;
  end

  initial begin
    int rand_start;
    bit pressure_done;
    pressure_done = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (opening_bytes[i]) send_byte(opening_bytes[i][7:0], opening_bytes[i][8]);
    settle();

    rand_start = bytes_sent;
    while (bytes_sent - rand_start < RAND_BYTES) begin
      if (!pressure_done && bytes_sent - rand_start >= RAND_BYTES / 2) begin
        // receiver holds off while the sender keeps offering
        pressure_done = 1'b1;
        tx_free = 1'b1;
        long_hold_req = 1'b1;
        repeat (20) begin
          put_valid_cp();
          send_seq($urandom_range(0, 9) == 0);
        end
        tx_free = 1'b0;
        settle();
      end
      if ($urandom_range(0, 19) == 0) tx_free = !tx_free;
      if ($urandom_range(0, 19) == 0) rx_free = !rx_free;
      if ($urandom_range(0, 3) != 0) put_valid_cp();
      else put_broken();
      send_seq($urandom_range(0, 9) == 0);
    end
    settle();
    repeat (20) @(posedge clk);

    $display("sent %0d bytes in %0d strings: valid, broken, overlong, surrogate,",
             bytes_sent, strings_sent);
    $display("out-of-range and truncated forms under random stalls; %0d results checked",
             result_count);
    if (fail_count == 0) begin
      $display("tb_utf8_display_width_meter_unit passed");
    end else begin
      $display("tb_utf8_display_width_meter_unit failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+sv
sv/udwm_pkg.sv
sv/utf8_display_width_meter_unit.sv
sv/udwm_checker.sv
sim/utf8_width_checker.sv
sim/tb_utf8_display_width_meter_unit.sv
